FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock and reset are the block's
// clk_i and rst_ni; checks are off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define PS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define PS_ASSERT(lbl, prop)
`define PS_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/psched_pkg.sv
package psched_pkg;

  // Default configuration
  localparam int unsigned MAX_PROCS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Fixed field widths
  localparam int unsigned ARR_W     = 16;
  localparam int unsigned BUR_W     = 16;
  localparam int unsigned PRI_W     = 8;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned TIME_W    = 21;
  localparam int unsigned AVG_W     = 29;

  typedef struct packed {
    logic [ARR_W-1:0] arrival_time;
    logic [BUR_W-1:0] burst_time;
    logic [PRI_W-1:0] prio_level;
    logic             last_process;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] process_index;
    logic [TIME_W-1:0]    completion_time;
    logic [TIME_W-1:0]    turnaround_time;
    logic [TIME_W-1:0]    waiting_time;
    logic [AVG_W-1:0]     avg_turnaround;
    logic [AVG_W-1:0]     avg_waiting;
    logic                 last_result;
    logic                 overflow;
  } out_item_t;

  // One stored process record
  typedef struct packed {
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
  } proc_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_ST,
    ST_SCAN,
    ST_COMMIT,
    ST_DIV_T_ST,
    ST_DIV_T_WAIT,
    ST_DIV_W_ST,
    ST_DIV_W_WAIT,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic commit;
    logic div_start;
    logic div_sel;
    logic div_cap;
    logic out_init;
    logic out_load;
    logic out_next;
    logic clear;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;
    logic sched_done;
    logic div_busy;
    logic out_last;
  } ctrl_stat_t;

endpackage

FILE: hw/rtl/psched_div.sv
// Restoring divider, one quotient bit per cycle.
module psched_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [DEN_W-1:0] denom_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W:0]    trial;
  logic              ge;

  // One shift-subtract step
  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W);
      rem_d  = '0;
      quo_d  = numer_i;
      den_d  = denom_i;
    end else if (busy_q) begin
      rem_d  = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

FILE: hw/rtl/psched_dp.sv
`include "assert_macros.svh"

// Record stores, schedule scan, sums, averages and result register.
module psched_dp #(
  parameter int unsigned MAX_PROCS = psched_pkg::MAX_PROCS_DEF,
  parameter int unsigned FRAC_BITS = psched_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psched_pkg::in_item_t  in_item_i,
  input  psched_pkg::ctrl_cmd_t cmd_i,
  output psched_pkg::ctrl_stat_t stat_o,
  output psched_pkg::out_item_t out_item_o
);

  import psched_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int unsigned TICK_W = ARR_W + CNT_W;
  localparam int unsigned SUM_W  = TICK_W + CNT_W;
  localparam int unsigned NUM_W  = SUM_W + FRAC_BITS;

  // Memories
  proc_rec_t          rec_mem [MAX_PROCS];
  logic [TICK_W-1:0]  cmp_mem [MAX_PROCS];
  proc_rec_t          rec_rd_q;
  logic [TICK_W-1:0]  cmp_rd_q;

  // Control state
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     done_q, done_d;
  logic                 drop_q, drop_d;
  logic [MAX_PROCS-1:0] fin_q, fin_d;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [SUM_W-1:0]     tsum_q, tsum_d;
  logic [SUM_W-1:0]     wsum_q, wsum_d;
  logic [IDX_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 issuing_q, issuing_d;
  logic                 ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]     ev_idx_q, ev_idx_d;
  logic                 found_q, found_d;
  logic                 pend_q, pend_d;

  // Scan payload
  logic [PRI_W-1:0]  best_pri_q, best_pri_d;
  logic [IDX_W-1:0]  pick_q, pick_d;
  logic [ARR_W-1:0]  pick_arr_q, pick_arr_d;
  logic [BUR_W-1:0]  pick_bur_q, pick_bur_d;
  logic [ARR_W-1:0]  next_arr_q, next_arr_d;
  logic [AVG_W-1:0]  avg_t_q, avg_t_d;
  logic [AVG_W-1:0]  avg_w_q, avg_w_d;
  out_item_t         out_q, out_d;

  logic [TICK_W-1:0] tick_new;
  logic [TICK_W-1:0] c_tat, c_wt;
  logic [TICK_W-1:0] o_tat, o_wt;
  logic              rd_last;
  logic              ev_last;
  logic [NUM_W-1:0]  div_num;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quot;

  assign rd_last  = (CNT_W'(rd_idx_q) == cnt_q - CNT_W'(1));
  assign ev_last  = (CNT_W'(ev_idx_q) == cnt_q - CNT_W'(1));
  assign tick_new = tick_q + TICK_W'(pick_bur_q);
  assign c_tat    = tick_new - TICK_W'(pick_arr_q);
  assign c_wt     = c_tat - TICK_W'(pick_bur_q);
  assign o_tat    = cmp_rd_q - TICK_W'(rec_rd_q.arr);
  assign o_wt     = o_tat - TICK_W'(rec_rd_q.bur);
  assign div_num  = NUM_W'(cmd_i.div_sel ? wsum_q : tsum_q) << FRAC_BITS;

  // Shared divider for both averages
  psched_div #(
    .NUM_W(NUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .numer_i(div_num),
    .denom_i(cnt_q),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  // Next-state logic
  always_comb begin
    cnt_d      = cnt_q;
    done_d     = done_q;
    drop_d     = drop_q;
    fin_d      = fin_q;
    tick_d     = tick_q;
    tsum_d     = tsum_q;
    wsum_d     = wsum_q;
    rd_idx_d   = rd_idx_q;
    issuing_d  = issuing_q;
    ev_vld_d   = issuing_q;
    ev_idx_d   = rd_idx_q;
    found_d    = found_q;
    pend_d     = pend_q;
    best_pri_d = best_pri_q;
    pick_d     = pick_q;
    pick_arr_d = pick_arr_q;
    pick_bur_d = pick_bur_q;
    next_arr_d = next_arr_q;
    avg_t_d    = avg_t_q;
    avg_w_d    = avg_w_q;
    out_d      = out_q;

    // load one record or flag the drop
    if (cmd_i.load) begin
      if (cnt_q < CNT_W'(MAX_PROCS)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        drop_d = 1'b1;
      end
    end

    // scan address sequencing
    if (cmd_i.scan_start) begin
      rd_idx_d  = '0;
      issuing_d = 1'b1;
      found_d   = 1'b0;
      pend_d    = 1'b0;
    end else if (issuing_q) begin
      if (rd_last) begin
        issuing_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + IDX_W'(1);
      end
    end

    // evaluate one entry per cycle
    if (ev_vld_q && !fin_q[ev_idx_q]) begin
      if (TICK_W'(rec_rd_q.arr) <= tick_q) begin
        if (!found_q || rec_rd_q.pri < best_pri_q) begin
          found_d    = 1'b1;
          best_pri_d = rec_rd_q.pri;
          pick_d     = ev_idx_q;
          pick_arr_d = rec_rd_q.arr;
          pick_bur_d = rec_rd_q.bur;
        end
      end else if (!pend_q || rec_rd_q.arr < next_arr_q) begin
        pend_d     = 1'b1;
        next_arr_d = rec_rd_q.arr;
      end
    end

    // run the pick to completion, or jump to the next arrival
    if (cmd_i.commit) begin
      if (found_q) begin
        tick_d         = tick_new;
        fin_d[pick_q]  = 1'b1;
        tsum_d         = tsum_q + SUM_W'(c_tat);
        wsum_d         = wsum_q + SUM_W'(c_wt);
        done_d         = done_q + CNT_W'(1);
      end else if (pend_q) begin
        tick_d = TICK_W'(next_arr_q);
      end
    end

    if (cmd_i.div_cap) begin
      if (cmd_i.div_sel) begin
        avg_w_d = AVG_W'(div_quot);
      end else begin
        avg_t_d = AVG_W'(div_quot);
      end
    end

    if (cmd_i.out_init) begin
      rd_idx_d = '0;
    end
    if (cmd_i.out_next) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
    end

    // result register
    if (cmd_i.out_load) begin
      out_d.process_index   = IDX_OUT_W'(rd_idx_q);
      out_d.completion_time = TIME_W'(cmp_rd_q);
      out_d.turnaround_time = TIME_W'(o_tat);
      out_d.waiting_time    = TIME_W'(o_wt);
      out_d.avg_turnaround  = rd_last ? avg_t_q : '0;
      out_d.avg_waiting     = rd_last ? avg_w_q : '0;
      out_d.last_result     = rd_last;
      out_d.overflow        = drop_q;
    end

    // back to the empty set
    if (cmd_i.clear) begin
      cnt_d  = '0;
      done_d = '0;
      drop_d = 1'b0;
      fin_d  = '0;
      tick_d = '0;
      tsum_d = '0;
      wsum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      done_q    <= '0;
      drop_q    <= 1'b0;
      fin_q     <= '0;
      tick_q    <= '0;
      tsum_q    <= '0;
      wsum_q    <= '0;
      rd_idx_q  <= '0;
      issuing_q <= 1'b0;
      ev_vld_q  <= 1'b0;
      ev_idx_q  <= '0;
      found_q   <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      drop_q    <= drop_d;
      fin_q     <= fin_d;
      tick_q    <= tick_d;
      tsum_q    <= tsum_d;
      wsum_q    <= wsum_d;
      rd_idx_q  <= rd_idx_d;
      issuing_q <= issuing_d;
      ev_vld_q  <= ev_vld_d;
      ev_idx_q  <= ev_idx_d;
      found_q   <= found_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_pri_q <= best_pri_d;
    pick_q     <= pick_d;
    pick_arr_q <= pick_arr_d;
    pick_bur_q <= pick_bur_d;
    next_arr_q <= next_arr_d;
    avg_t_q    <= avg_t_d;
    avg_w_q    <= avg_w_d;
    out_q      <= out_d;
  end

  // Record store: written on load, read every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cnt_q < CNT_W'(MAX_PROCS)) begin
      rec_mem[cnt_q[IDX_W-1:0]] <= '{arr: in_item_i.arrival_time,
                                     bur: in_item_i.burst_time,
                                     pri: in_item_i.prio_level};
    end
    rec_rd_q <= rec_mem[rd_idx_q];
  end

  // Completion store: written when a commit runs a process, read every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && found_q) begin
      cmp_mem[pick_q] <= tick_new;
    end
    cmp_rd_q <= cmp_mem[rd_idx_q];
  end

  assign stat_o.scan_end   = ev_vld_q && ev_last;
  assign stat_o.sched_done = found_q && (done_q + CNT_W'(1) == cnt_q);
  assign stat_o.div_busy   = div_busy;
  assign stat_o.out_last   = rd_last;
  assign out_item_o        = out_q;

  // A round always has either a ready process or a pending arrival
  `PS_ASSERT(a_commit_has_work, cmd_i.commit |-> (found_q || pend_q))
  // Running a process never moves the clock backward
  `PS_ASSERT(a_tick_monotonic, (cmd_i.commit && found_q) |=> (tick_q >= $past(tick_q)))
  // Items are dropped only once the store is full
  `PS_ASSERT_MSG(a_drop_full, drop_q |-> (cnt_q == CNT_W'(MAX_PROCS)), "drop without full store")

endmodule

FILE: hw/rtl/psched_ctrl.sv
// Sequencer: load, schedule rounds, two divisions, result readout.
module psched_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  input  logic                   out_ready_i,
  input  psched_pkg::ctrl_stat_t stat_i,
  output psched_pkg::ctrl_cmd_t  cmd_o,
  output logic                   in_ready_o,
  output logic                   out_valid_o
);

  import psched_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_SCAN_ST;
      end
      ST_SCAN_ST:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (stat_i.scan_end) state_d = ST_COMMIT;
      end
      ST_COMMIT:   state_d = stat_i.sched_done ? ST_DIV_T_ST : ST_SCAN_ST;
      ST_DIV_T_ST: state_d = ST_DIV_T_WAIT;
      ST_DIV_T_WAIT: begin
        if (!stat_i.div_busy) state_d = ST_DIV_W_ST;
      end
      ST_DIV_W_ST: state_d = ST_DIV_W_WAIT;
      ST_DIV_W_WAIT: begin
        if (!stat_i.div_busy) state_d = ST_OUT_RD;
      end
      ST_OUT_RD:   state_d = ST_OUT_LD;
      ST_OUT_LD:   state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_ready_i) state_d = stat_i.out_last ? ST_IDLE : ST_OUT_RD;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN_ST:  cmd_o.scan_start = 1'b1;
      ST_SCAN:     ;
      ST_COMMIT:   cmd_o.commit = 1'b1;
      ST_DIV_T_ST: cmd_o.div_start = 1'b1;
      ST_DIV_T_WAIT: begin
        cmd_o.div_cap = !stat_i.div_busy;
      end
      ST_DIV_W_ST: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        cmd_o.out_init  = 1'b1;
      end
      ST_DIV_W_WAIT: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.div_cap = !stat_i.div_busy;
      end
      ST_OUT_RD:   ;
      ST_OUT_LD:   cmd_o.out_load = 1'b1;
      ST_OUT_WAIT: begin
        out_valid_o    = 1'b1;
        cmd_o.out_next = out_ready_i && !stat_i.out_last;
        cmd_o.clear    = out_ready_i && stat_i.out_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/priority_nonpreemptive_scheduler_unit.sv
// Non-preemptive priority scheduler.
// Input channel (in_valid_i / in_ready_o / in_item_i): one process record per
// item, taken one per cycle while the unit is loading. The item with
// last_process set closes the set and starts the schedule; items beyond
// MAX_PROCS are dropped and the overflow bit is set on every result.
// Schedule: each round scans the N loaded records, one per cycle from the
// record memory read port, then commits, with at most 2N rounds (a round
// either finishes a process or jumps to the next arrival). Averages then
// take two passes of a one-bit-per-cycle divider of width NUM_W, where
// NUM_W = 16 + 2 * clog2(MAX_PROCS+1) + FRAC_BITS.
// Output channel (out_valid_o / out_ready_i / out_item_o): N results in load
// order; the last carries the averages. A stalled receiver holds the
// current result; no new set is accepted until the last result is taken,
// after which the count, marks, clock and sums return to empty.
// Reset: asynchronous, active low; clears the count, marks, clock and sums.
// No clearing pass is needed.
module priority_nonpreemptive_scheduler_unit #(
  parameter int unsigned MAX_PROCS = psched_pkg::MAX_PROCS_DEF,
  parameter int unsigned FRAC_BITS = psched_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  psched_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output psched_pkg::out_item_t out_item_o
);

  import psched_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  psched_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last_process),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o)
  );

  psched_dp #(
    .MAX_PROCS(MAX_PROCS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_item_o(out_item_o)
  );

endmodule

FILE: verif/priority_nonpreemptive_scheduler_unit_tb.sv
`timescale 1ns / 100ps

module priority_nonpreemptive_scheduler_unit_tb;
  import psched_pkg::*;

  localparam int unsigned MAX_P     = MAX_PROCS_DEF;
  localparam int unsigned FRAC      = FRAC_BITS_DEF;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned RAND_ITEMS = 225;

  // DUT connections, known from time zero
  logic      clk_i     = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item   = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  // Idling control shared by the test tasks and the receiver
  int unsigned tx_max_gap = 11;
  int unsigned rx_max_gap = 11;
  int unsigned hold_len   = 0;
  int unsigned items_sent = 0;
  int unsigned err_count  = 0;

  // Predictor state: the loaded process table
  logic [ARR_W-1:0] proc_arr [MAX_P];
  logic [BUR_W-1:0] proc_bur [MAX_P];
  logic [PRI_W-1:0] proc_pri [MAX_P];
  int unsigned      loaded_n = 0;
  bit               dropped  = 1'b0;

  // Reports predicted but not yet seen on the output
  out_item_t pending_reports [$];

  priority_nonpreemptive_scheduler_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Load one record; on the closing item run the schedule and queue the reports
  function automatic void load_process_and_schedule(input in_item_t it);
    longint unsigned tick, best_pri, next_arr, tat, wt, sum_t, sum_w;
    longint unsigned finish_at [MAX_P];
    bit              finished [MAX_P];
    int unsigned     pick, done;
    bit              found, pend;
    out_item_t       rep;
    if (loaded_n < MAX_P) begin
      proc_arr[loaded_n] = it.arrival_time;
      proc_bur[loaded_n] = it.burst_time;
      proc_pri[loaded_n] = it.prio_level;
      loaded_n++;
    end else begin
      dropped = 1'b1;
    end
    if (!it.last_process) return;

    for (int unsigned i = 0; i < MAX_P; i++) begin
      finished[i]  = 1'b0;
      finish_at[i] = 0;
    end
    tick = 0;
    done = 0;
    // Each round: lowest priority among arrived, ties to lowest index
    while (done < loaded_n) begin
      found    = 1'b0;
      pend     = 1'b0;
      pick     = 0;
      best_pri = 0;
      next_arr = 0;
      for (int unsigned i = 0; i < loaded_n; i++) begin
        if (!finished[i]) begin
          if (longint'(proc_arr[i]) <= tick) begin
            if (!found || proc_pri[i] < best_pri) begin
              found    = 1'b1;
              best_pri = proc_pri[i];
              pick     = i;
            end
          end else if (!pend || proc_arr[i] < next_arr) begin
            pend     = 1'b1;
            next_arr = proc_arr[i];
          end
        end
      end
      if (found) begin
        tick            = tick + proc_bur[pick];
        finish_at[pick] = tick;
        finished[pick]  = 1'b1;
        done++;
      end else if (pend) begin
        tick = next_arr;
      end else begin
        break;
      end
    end

    sum_t = 0;
    sum_w = 0;
    for (int unsigned i = 0; i < loaded_n; i++) begin
      tat   = finish_at[i] - proc_arr[i];
      sum_t = sum_t + tat;
      sum_w = sum_w + (tat - proc_bur[i]);
    end

    for (int unsigned i = 0; i < loaded_n; i++) begin
      tat = finish_at[i] - proc_arr[i];
      wt  = tat - proc_bur[i];
      rep = '0;
      rep.process_index   = IDX_OUT_W'(i);
      rep.completion_time = TIME_W'(finish_at[i]);
      rep.turnaround_time = TIME_W'(tat);
      rep.waiting_time    = TIME_W'(wt);
      rep.last_result     = (i + 1 == loaded_n);
      rep.overflow        = dropped;
      if (rep.last_result) begin
        rep.avg_turnaround = AVG_W'((sum_t << FRAC) / loaded_n);
        rep.avg_waiting    = AVG_W'((sum_w << FRAC) / loaded_n);
      end
      pending_reports.push_back(rep);
    end
    loaded_n = 0;
    dropped  = 1'b0;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Monitor: predict on accepted input, check each accepted result
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready_o) load_process_and_schedule(in_item);
      if (out_valid_o && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result for process %0d", out_item_o.process_index);
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("process_index", want.process_index, out_item_o.process_index);
          check_field("completion_time", want.completion_time, out_item_o.completion_time);
          check_field("turnaround_time", want.turnaround_time, out_item_o.turnaround_time);
          check_field("waiting_time", want.waiting_time, out_item_o.waiting_time);
          check_field("avg_turnaround", want.avg_turnaround, out_item_o.avg_turnaround);
          check_field("avg_waiting", want.avg_waiting, out_item_o.avg_waiting);
          check_field("last_result", want.last_result, out_item_o.last_result);
          check_field("overflow", want.overflow, out_item_o.overflow);
        end
      end
    end
  end

  // Receiver: random wait before each result, long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        gap       = hold_len;
        hold_len  = 0;
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        gap = $urandom_range(0, rx_max_gap);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_len == 0);
    end
  end

  // Watchdog on cycles with no handshake on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("priority_nonpreemptive_scheduler_unit_tb: errors");
    $finish;
  end

  // Offer one item after a random gap, return at the accepting edge
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  function automatic in_item_t make_proc(input int unsigned arr, input int unsigned bur,
                                         input int unsigned pri, input bit last);
    in_item_t it;
    it.arrival_time = ARR_W'(arr);
    it.burst_time   = BUR_W'(bur);
    it.prio_level   = PRI_W'(pri);
    it.last_process = last;
    return it;
  endfunction

  // Sender pause until the block has reported everything; the first edge
  // lets the monitor take in the item accepted at the current edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Random set: wide mode spans full ranges, tight mode forces contention
  task automatic send_random_set(input int unsigned n);
    bit          tight;
    bit          few_prios;
    int unsigned arr, bur, pri;
    tight     = $urandom_range(0, 2) != 0;
    few_prios = $urandom_range(0, 1);
    for (int unsigned k = 0; k < n; k++) begin
      arr = tight ? $urandom_range(0, 40) : $urandom_range(0, 65535);
      bur = tight ? $urandom_range(0, 20) : $urandom_range(0, 65535);
      pri = few_prios ? $urandom_range(0, 3) : $urandom_range(0, 255);
      send_item(make_proc(arr, bur, pri, k == n - 1));
    end
  endtask

  task automatic test_single_process();
    send_item(make_proc(0, 0, 0, 1'b1));
    wait_drained();
  endtask

  task automatic test_field_extremes();
    send_item(make_proc(65535, 65535, 255, 1'b1));
    wait_drained();
  endtask

  // Idle jumps to the next arrival and equal priorities
  task automatic test_ties_and_gaps();
    send_item(make_proc(10, 5, 3, 1'b0));
    send_item(make_proc(10, 2, 3, 1'b0));
    send_item(make_proc(4, 1, 255, 1'b1));
    wait_drained();
  endtask

  // Full table at the widest times, two dropped items, the last one closing
  task automatic test_capacity_overflow();
    for (int unsigned k = 0; k < MAX_P; k++)
      send_item(make_proc(65535, 65535, $urandom_range(0, 255), 1'b0));
    send_item(make_proc($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 255), 1'b0));
    send_item(make_proc($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 255), 1'b1));
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering sets back to back
  task automatic test_output_holdoff();
    tx_max_gap = 0;
    hold_len   = HOLD_LEN;
    repeat (3) send_random_set(4);
    wait_drained();
    tx_max_gap = 11;
  endtask

  task automatic test_random_sets();
    int unsigned start_cnt, sel, n;
    start_cnt = items_sent;
    while (items_sent - start_cnt < RAND_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) n = $urandom_range(1, 8);
      else if (sel == 8) n = $urandom_range(9, MAX_P);
      else n = $urandom_range(MAX_P + 1, MAX_P + 4);
      tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
      rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
      send_random_set(n);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    tx_max_gap = 11;
    rx_max_gap = 11;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_single_process();
    test_field_extremes();
    test_ties_and_gaps();
    test_capacity_overflow();
    test_output_holdoff();
    test_random_sets();

    // Drain and watch for stray results
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      err_count++;
    end
    if (err_count == 0)
      $display("priority_nonpreemptive_scheduler_unit_tb: clean");
    else
      $display("priority_nonpreemptive_scheduler_unit_tb: errors");
    $finish;
  end

endmodule
